// ----- rtl/assert_macros.svh -----
// assertion macros shared by the polar unwrap sampler rtl
// expects clk and rst_n (active-low reset) in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pus_pkg.sv -----
// types, constants and the sine rom of the polar unwrap sampler
// no dependencies; used by pus_if, pus_coord, pus_store and the core
`default_nettype none

package pus_pkg;

  // store geometry and pixel width
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int PIXEL_BITS  = 32;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  // angle and fixed point arithmetic
  localparam int ANGLE_STEPS = 360;
  localparam int QUARTER     = ANGLE_STEPS / 4;
  localparam int ANGLE_W     = 9;
  localparam int STEP_W      = 9;
  localparam int REG_W       = 9;
  localparam int TRIG_W      = 18;  // signed q1.16
  localparam int Q_FRAC      = 16;
  localparam int SUM_W       = 28;  // j*trig plus centre offset, signed q16
  localparam int CRD_W       = 13;  // rounded coordinate, signed

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef enum logic {
    CMD_WRITE  = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_IMAGE_WIDTH  = 3'd2,
    REG_IMAGE_HEIGHT = 3'd3,
    REG_RAY_LENGTH   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    cmd_t              command;
    logic [7:0]        pixel_row;
    logic [7:0]        pixel_col;
    logic [31:0]       pixel_value;
    logic [ANGLE_W-1:0] angle_step;
    logic [STEP_W-1:0] ray_step;
  } in_item_t;

  typedef struct packed {
    logic [31:0]        sample_value;
    logic               inside_res;
    logic [STEP_W-1:0]  out_row;
    logic [ANGLE_W-1:0] out_col;
  } out_item_t;

  typedef struct packed {
    cfg_reg_t         reg_index;
    logic [REG_W-1:0] reg_value;
  } cfg_item_t;

  typedef struct packed {
    logic [REG_W-1:0] center_x;
    logic [REG_W-1:0] center_y;
    logic [REG_W-1:0] image_width;
    logic [REG_W-1:0] image_height;
    logic [REG_W-1:0] ray_length;
  } cfg_regs_t;

  // request from the coordinate pipeline to the store stage
  typedef struct packed {
    logic                  valid;
    cmd_t                  cmd;
    logic                  hit;    // sample: point in image; write: pixel in store
    logic [ADDR_BITS-1:0]  addr;
    logic [PIXEL_BITS-1:0] wdata;
    logic [STEP_W-1:0]     out_row;
    logic [ANGLE_W-1:0]    out_col;
  } store_req_t;

  typedef logic signed [TRIG_W-1:0] sine_tab_t [ANGLE_STEPS];

  // q16 sine of k degrees for k in 0..90, taylor series evaluated in q30
  function automatic logic signed [TRIG_W-1:0] quarter_sine(input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned rnd;
    longint          sum;
    x    = (longint'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    sum  = longint'(x);
    term = ((x * x2) >> 30) / 64'd6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    rnd = (longint'(sum) + 64'd8192) >> 14;
    return TRIG_W'(rnd);
  endfunction

  // full circle by quadrant symmetry, built at elaboration
  function automatic sine_tab_t build_sine_rom();
    sine_tab_t tab;
    for (int unsigned d = 0; d < ANGLE_STEPS; d++) begin
      if (d < QUARTER) begin
        tab[d] = quarter_sine(d);
      end else if (d < 2 * QUARTER) begin
        tab[d] = quarter_sine(2 * QUARTER - d);
      end else if (d < 3 * QUARTER) begin
        tab[d] = -quarter_sine(d - 2 * QUARTER);
      end else begin
        tab[d] = -quarter_sine(ANGLE_STEPS - d);
      end
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

// ----- rtl/pus_if.sv -----
// valid/ready channel interfaces of the polar unwrap sampler
// depends on pus_pkg for the payload types
`default_nettype none

interface pus_in_if;
  logic               valid;
  logic               ready;
  pus_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pus_out_if;
  logic               valid;
  logic               ready;
  pus_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pus_cfg_if;
  logic               valid;
  logic               ready;
  pus_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/pus_coord.sv -----
// four-stage coordinate pipeline: trig lookup, multiply, offset add, round and bounds
// depends on pus_pkg
`default_nettype none

module pus_coord (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   in_valid,
  input  pus_pkg::in_item_t      in_item,
  input  pus_pkg::cfg_regs_t     cfg,
  output pus_pkg::store_req_t    req
);

  localparam logic signed [pus_pkg::SUM_W-1:0] ONE_S = pus_pkg::SUM_W'(1);
  localparam logic [pus_pkg::SUM_W-1:0] HALF_Q = pus_pkg::SUM_W'(1) << (pus_pkg::Q_FRAC - 1);
  localparam logic [pus_pkg::ANGLE_W-1:0] FULL_A = pus_pkg::ANGLE_W'(pus_pkg::ANGLE_STEPS);
  localparam logic [pus_pkg::ANGLE_W-1:0] QTR_A = pus_pkg::ANGLE_W'(pus_pkg::QUARTER);
  localparam logic [pus_pkg::ANGLE_W-1:0] TQTR_A = pus_pkg::ANGLE_W'(3 * pus_pkg::QUARTER);

  // write fields travel alongside the sample math
  typedef struct packed {
    logic                          valid;
    pus_pkg::cmd_t                 cmd;
    logic [7:0]                    prow;
    logic [7:0]                    pcol;
    logic [pus_pkg::PIXEL_BITS-1:0] pval;
    logic [pus_pkg::STEP_W-1:0]    out_row;
    logic [pus_pkg::ANGLE_W-1:0]   out_col;
  } side_t;

  // q16 to integer, half away from zero
  function automatic logic signed [pus_pkg::CRD_W-1:0] round_q16(
    input logic signed [pus_pkg::SUM_W-1:0] p
  );
    logic [pus_pkg::SUM_W-1:0] mag_abs;
    logic [pus_pkg::SUM_W-1:0] mag;
    mag_abs = p[pus_pkg::SUM_W-1] ? pus_pkg::SUM_W'(-p) : pus_pkg::SUM_W'(p);
    mag     = (mag_abs + HALF_Q) >> pus_pkg::Q_FRAC;
    return p[pus_pkg::SUM_W-1] ? -$signed(pus_pkg::CRD_W'(mag))
                               : $signed(pus_pkg::CRD_W'(mag));
  endfunction

  side_t side1_r, side2_r, side3_r;
  side_t side1_nxt;

  logic signed [pus_pkg::TRIG_W-1:0] cos1_r, nsin1_r;
  logic [pus_pkg::STEP_W-1:0]        j1_r;
  logic signed [pus_pkg::SUM_W-1:0]  pc2_r, ps2_r;
  logic signed [pus_pkg::SUM_W-1:0]  sc3_r, ss3_r;
  pus_pkg::store_req_t               req_r, req_nxt;

  logic [pus_pkg::ANGLE_W-1:0]       a_mod, cos_idx;
  logic signed [pus_pkg::SUM_W-1:0]  cx_s, cy_s, off_x, off_y;
  logic signed [pus_pkg::CRD_W-1:0]  col_c, row_c;
  logic [pus_pkg::CRD_W-1:0]         wlim, hlim;
  logic                              in_img, in_store;

  // stage 1: angle reduction, table lookup, destination position
  always_comb begin
    a_mod   = (in_item.angle_step >= FULL_A) ? in_item.angle_step - FULL_A
                                             : in_item.angle_step;
    cos_idx = (a_mod >= TQTR_A) ? a_mod - TQTR_A : a_mod + QTR_A;
    side1_nxt.valid   = in_valid;
    side1_nxt.cmd     = in_item.command;
    side1_nxt.prow    = in_item.pixel_row;
    side1_nxt.pcol    = in_item.pixel_col;
    side1_nxt.pval    = pus_pkg::PIXEL_BITS'(in_item.pixel_value);
    side1_nxt.out_row = cfg.ray_length - in_item.ray_step - pus_pkg::STEP_W'(1);
    side1_nxt.out_col = (a_mod == '0) ? FULL_A - pus_pkg::ANGLE_W'(1)
                                      : a_mod - pus_pkg::ANGLE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cos1_r  <= pus_pkg::SINE_ROM[cos_idx];
      nsin1_r <= -pus_pkg::SINE_ROM[a_mod];
      j1_r    <= in_item.ray_step;
    end
  end

  // stage 2: ray step times cosine and negated sine
  always_ff @(posedge clk) begin
    if (adv) begin
      pc2_r <= $signed({1'b0, j1_r}) * cos1_r;
      ps2_r <= $signed({1'b0, j1_r}) * nsin1_r;
    end
  end

  // stage 3: add the centre offset, (c - 1) in q16
  always_comb begin
    cx_s  = $signed(pus_pkg::SUM_W'(cfg.center_x));
    cy_s  = $signed(pus_pkg::SUM_W'(cfg.center_y));
    off_x = (cx_s - ONE_S) <<< pus_pkg::Q_FRAC;
    off_y = (cy_s - ONE_S) <<< pus_pkg::Q_FRAC;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sc3_r <= pc2_r + off_x;
      ss3_r <= ps2_r + off_y;
    end
  end

  // stage 4: round, bounds check against the clipped image size, address
  always_comb begin
    col_c = round_q16(sc3_r);
    row_c = round_q16(ss3_r);
    wlim  = (pus_pkg::CRD_W'(cfg.image_width) > pus_pkg::CRD_W'(pus_pkg::MAX_WIDTH))
            ? pus_pkg::CRD_W'(pus_pkg::MAX_WIDTH) : pus_pkg::CRD_W'(cfg.image_width);
    hlim  = (pus_pkg::CRD_W'(cfg.image_height) > pus_pkg::CRD_W'(pus_pkg::MAX_HEIGHT))
            ? pus_pkg::CRD_W'(pus_pkg::MAX_HEIGHT) : pus_pkg::CRD_W'(cfg.image_height);
    in_img = !col_c[pus_pkg::CRD_W-1] && !row_c[pus_pkg::CRD_W-1] &&
             ($unsigned(col_c) < wlim) && ($unsigned(row_c) < hlim);
    in_store = (pus_pkg::CRD_W'(side3_r.prow) < pus_pkg::CRD_W'(pus_pkg::MAX_HEIGHT)) &&
               (pus_pkg::CRD_W'(side3_r.pcol) < pus_pkg::CRD_W'(pus_pkg::MAX_WIDTH));
    req_nxt.valid   = side3_r.valid;
    req_nxt.cmd     = side3_r.cmd;
    req_nxt.wdata   = side3_r.pval;
    req_nxt.out_row = side3_r.out_row;
    req_nxt.out_col = side3_r.out_col;
    if (side3_r.cmd == pus_pkg::CMD_SAMPLE) begin
      req_nxt.hit  = in_img;
      req_nxt.addr = {pus_pkg::ROW_BITS'($unsigned(row_c)),
                      pus_pkg::COL_BITS'($unsigned(col_c))};
    end else begin
      req_nxt.hit  = in_store;
      req_nxt.addr = {pus_pkg::ROW_BITS'(side3_r.prow), pus_pkg::COL_BITS'(side3_r.pcol)};
    end
  end

  // side-band and stage valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side1_r.valid <= 1'b0;
      side2_r.valid <= 1'b0;
      side3_r.valid <= 1'b0;
      req_r.valid   <= 1'b0;
    end else if (adv) begin
      side1_r <= side1_nxt;
      side2_r <= side1_r;
      side3_r <= side2_r;
      req_r   <= req_nxt;
    end
  end

  assign req = req_r;

endmodule

`default_nettype wire

// ----- rtl/pus_store.sv -----
// image store stage: single-port pixel memory and the result register
// depends on pus_pkg
`default_nettype none

module pus_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  pus_pkg::store_req_t  req,
  output logic                 res_valid,
  output pus_pkg::out_item_t   res_item
);

  logic [pus_pkg::PIXEL_BITS-1:0] mem [pus_pkg::STORE_DEPTH];
  logic [pus_pkg::PIXEL_BITS-1:0] rdata_r;
  logic                           valid_r;
  pus_pkg::cmd_t                  cmd_r;
  logic                           hit_r;
  logic [pus_pkg::STEP_W-1:0]     out_row_r;
  logic [pus_pkg::ANGLE_W-1:0]    out_col_r;

  // one access a cycle while the pipeline advances, in transaction order: write or registered read
  always_ff @(posedge clk) begin
    if (adv && req.valid) begin
      if (req.cmd == pus_pkg::CMD_WRITE) begin
        if (req.hit) begin
          mem[req.addr] <= req.wdata;
        end
      end else begin
        rdata_r <= mem[req.addr];
      end
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r     <= req.cmd;
      hit_r     <= req.hit;
      out_row_r <= req.out_row;
      out_col_r <= req.out_col;
    end
  end

  // writes retire here without a result
  assign res_valid             = valid_r && (cmd_r == pus_pkg::CMD_SAMPLE);
  assign res_item.sample_value = hit_r ? 32'(rdata_r) : '0;
  assign res_item.inside_res   = hit_r;
  assign res_item.out_row      = out_row_r;
  assign res_item.out_col      = out_col_r;

endmodule

`default_nettype wire

// ----- rtl/polar_unwrap_sampler_core.sv -----
// a sample passes the coordinate pipeline, then the registered store read
// throughput: one write or sample per cycle, any mix, unless stalled; the single
//   store port takes either one pixel write or one pixel read per cycle
// reset: pipeline valid bits clear and the registers take their defaults
//   (centre 0,0; image 256x256; ray length 363); the image store is not cleared
// depends on pus_pkg, pus_if, pus_coord, pus_store, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module polar_unwrap_sampler_core (
  input  logic         clk,
  input  logic         rst_n,
  pus_in_if.sink       in_ch,
  pus_out_if.source    out_ch,
  pus_cfg_if.sink      cfg_ch
);

  pus_pkg::cfg_regs_t  cfg_r;
  pus_pkg::store_req_t store_req;
  logic                adv;
  logic                res_valid;
  pus_pkg::out_item_t  res_item;

  // the whole pipeline moves unless a result waits on the output
  assign adv         = !res_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_x     <= '0;
      cfg_r.center_y     <= '0;
      cfg_r.image_width  <= pus_pkg::REG_W'(256);
      cfg_r.image_height <= pus_pkg::REG_W'(256);
      cfg_r.ray_length   <= pus_pkg::REG_W'(363);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.data.reg_index)
        pus_pkg::REG_CENTER_X:     cfg_r.center_x     <= cfg_ch.data.reg_value;
        pus_pkg::REG_CENTER_Y:     cfg_r.center_y     <= cfg_ch.data.reg_value;
        pus_pkg::REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_ch.data.reg_value;
        pus_pkg::REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_ch.data.reg_value;
        pus_pkg::REG_RAY_LENGTH:   cfg_r.ray_length   <= cfg_ch.data.reg_value;
        default: begin
        end
      endcase
    end
  end

  // coordinate pipeline
  pus_coord u_coord (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_ch.valid),
    .in_item  (in_ch.data),
    .cfg      (cfg_r),
    .req      (store_req)
  );

  // pixel store and result register
  pus_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .req       (store_req),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.data  = res_item;

  // checks
  `ASSERT_IMPLIES(a_outside_is_zero, out_ch.valid && !out_ch.data.inside_res,
    out_ch.data.sample_value == '0, "outside sample carries a nonzero value")
  `ASSERT_NEXT(a_stall_freezes_pipe, !adv, $stable(store_req),
    "store request changed while the pipeline was stalled")
  `ASSERT_IMPLIES(a_col_in_range, out_ch.valid,
    out_ch.data.out_col < pus_pkg::ANGLE_W'(pus_pkg::ANGLE_STEPS),
    "polar column beyond the angle range")

endmodule

`default_nettype wire
